[rtl/assert_macros.svh]
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define PCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/pcs_pkg.sv]
`timescale 1ns / 1ps
package pcs_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int SUM_W      = 40;
    localparam int SQ_W       = 64;
    localparam int CNT_OUT_W  = 17;
    localparam int COEF_W     = 32;
    localparam int ST_W       = 2;
    localparam int VW         = 82;
    localparam int MW         = 80;
    localparam int PW         = 2 * MW;
    localparam int QW         = 61;
    localparam int RW         = QW + 1;
    localparam int ROOT_STEPS = RW / 2;
    localparam int STEP_W     = $clog2(MW + 1);

    typedef logic [ST_W-1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FLAT  = 2'd2;
    localparam status_t ST_OVF   = 2'd3;

    typedef enum logic [2:0] {
        MS_N_SAB,
        MS_SA_SB,
        MS_N_SAA,
        MS_SA_SA,
        MS_N_SBB,
        MS_SB_SB,
        MS_MAG_MAG,
        MS_VA_VB
    } mul_sel_t;

    typedef struct packed {
        logic     acc_en;
        logic     mul_load;
        logic     mul_step;
        logic     mul_store;
        mul_sel_t sel;
        logic     div_load;
        logic     div_step;
        logic     root_load;
        logic     root_step;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    function automatic logic [MW-1:0] mag_of(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] t;
        t = v[VW-1] ? -v : v;
        return t[MW-1:0];
    endfunction

endpackage

[rtl/pcs_ifs.sv]
`timescale 1ns / 1ps
interface pcs_pair_if import pcs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] a_sample;
    logic                       a_missing;
    logic signed [SAMPLE_W-1:0] b_sample;
    logic                       b_missing;
    logic                       last_pair;

    modport source (output valid, a_sample, a_missing, b_sample, b_missing, last_pair,
                    input ready);
    modport sink   (input valid, a_sample, a_missing, b_sample, b_missing, last_pair,
                    output ready);
endinterface

interface pcs_result_if import pcs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coefficient;
    logic [CNT_OUT_W-1:0]     pairs_used;
    logic [ST_W-1:0]          status;

    modport source (output valid, coefficient, pairs_used, status, input ready);
    modport sink   (input valid, coefficient, pairs_used, status, output ready);
endinterface

[rtl/pcs_ctrl.sv]
`timescale 1ns / 1ps
module pcs_ctrl import pcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     in_last,
    input  dp_stat_t stat,
    output logic     in_ready,
    output dp_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_ACCUM  = 9'b000000001,
        S_MLOAD  = 9'b000000010,
        S_MRUN   = 9'b000000100,
        S_MSTORE = 9'b000001000,
        S_DLOAD  = 9'b000010000,
        S_DRUN   = 9'b000100000,
        S_RLOAD  = 9'b001000000,
        S_RRUN   = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    mul_sel_t          sel_reg, sel_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.sel    = sel_reg;
        unique case (state_reg)
            S_ACCUM:
            begin
                in_ready   = 1'b1;
                cmd.acc_en = in_fire;
                if (in_fire && in_last)
                begin
                    sel_next   = MS_N_SAB;
                    state_next = S_MLOAD;
                end
            end
            S_MLOAD:
            begin
                cmd.mul_load = 1'b1;
                step_next    = '0;
                state_next   = S_MRUN;
            end
            S_MRUN:
            begin
                cmd.mul_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MW - 1))
                    state_next = S_MSTORE;
            end
            S_MSTORE:
            begin
                cmd.mul_store = 1'b1;
                if (sel_reg == MS_VA_VB)
                    state_next = S_DLOAD;
                else
                begin
                    sel_next   = mul_sel_t'(sel_reg + 3'd1);
                    state_next = S_MLOAD;
                end
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DRUN;
            end
            S_DRUN:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QW - 1))
                    state_next = S_RLOAD;
            end
            S_RLOAD:
            begin
                cmd.root_load = 1'b1;
                step_next     = '0;
                state_next    = S_RRUN;
            end
            S_RRUN:
            begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_ACCUM;
                end
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACCUM;
            sel_reg   <= MS_N_SAB;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
        end
    end

endmodule

[rtl/pcs_dp.sv]
`timescale 1ns / 1ps
module pcs_dp import pcs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    output dp_stat_t                   stat,
    input  logic signed [SAMPLE_W-1:0] a_sample,
    input  logic                       a_missing,
    input  logic signed [SAMPLE_W-1:0] b_sample,
    input  logic                       b_missing,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [COEF_W-1:0]   coefficient,
    output logic [CNT_OUT_W-1:0]       pairs_used,
    output logic [ST_W-1:0]            status
);

    localparam int CW = COUNT_BITS + 1;
    localparam int SH = SAMPLE_W - SAMPLE_BITS;

    // running sums
    logic signed [SUM_W-1:0] sa_reg, sb_reg;
    logic signed [SQ_W-1:0]  sab_reg, saa_reg, sbb_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    ovf_reg;

    logic signed [SAMPLE_W-1:0]   a_shl, b_shl, a_val, b_val;
    logic signed [2*SAMPLE_W-1:0] p_ab, p_aa, p_bb;
    logic                         use_pair;

    assign a_shl    = a_sample <<< SH;
    assign b_shl    = b_sample <<< SH;
    assign a_val    = a_shl >>> SH;
    assign b_val    = b_shl >>> SH;
    assign p_ab     = a_val * b_val;
    assign p_aa     = a_val * a_val;
    assign p_bb     = b_val * b_val;
    assign use_pair = cmd.acc_en && !a_missing && !b_missing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg  <= '0;
            sb_reg  <= '0;
            sab_reg <= '0;
            saa_reg <= '0;
            sbb_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            sa_reg  <= '0;
            sb_reg  <= '0;
            sab_reg <= '0;
            saa_reg <= '0;
            sbb_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (use_pair)
        begin
            if (cnt_reg[COUNT_BITS])
                ovf_reg <= 1'b1;
            else
            begin
                sa_reg  <= sa_reg + SUM_W'(a_val);
                sb_reg  <= sb_reg + SUM_W'(b_val);
                sab_reg <= sab_reg + SQ_W'(p_ab);
                saa_reg <= saa_reg + SQ_W'(p_aa);
                sbb_reg <= sbb_reg + SQ_W'(p_bb);
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    // shared shift-add multiplier on magnitudes
    logic signed [VW-1:0] op_a, op_b, n_val;
    logic [MW-1:0]        mcand_reg;
    logic [PW-1:0]        p_reg;
    logic                 mneg_reg;
    logic [MW:0]          mul_sum;
    logic signed [VW-1:0] sprod;
    logic signed [VW-1:0] tmp_reg, num_reg, va_reg, vb_reg;
    logic [PW-1:0]        magsq_reg;

    assign n_val = VW'(cnt_reg);

    always_comb
    begin
        case (cmd.sel)
            MS_N_SAB:   begin op_a = n_val;       op_b = VW'(sab_reg); end
            MS_SA_SB:   begin op_a = VW'(sa_reg); op_b = VW'(sb_reg);  end
            MS_N_SAA:   begin op_a = n_val;       op_b = VW'(saa_reg); end
            MS_SA_SA:   begin op_a = VW'(sa_reg); op_b = VW'(sa_reg);  end
            MS_N_SBB:   begin op_a = n_val;       op_b = VW'(sbb_reg); end
            MS_SB_SB:   begin op_a = VW'(sb_reg); op_b = VW'(sb_reg);  end
            MS_MAG_MAG: begin op_a = num_reg;     op_b = num_reg;      end
            MS_VA_VB:   begin op_a = va_reg;      op_b = vb_reg;       end
            default:    begin op_a = n_val;       op_b = VW'(sab_reg); end
        endcase
    end

    assign mul_sum = {1'b0, p_reg[PW-1:MW]} + (p_reg[0] ? {1'b0, mcand_reg} : '0);
    assign sprod   = mneg_reg ? -VW'(p_reg) : VW'(p_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            mcand_reg <= mag_of(op_a);
            p_reg     <= {MW'(0), mag_of(op_b)};
            mneg_reg  <= op_a[VW-1] ^ op_b[VW-1];
        end
        else if (cmd.mul_step)
            p_reg <= {mul_sum, p_reg[MW-1:1]};

        if (cmd.mul_store)
        begin
            case (cmd.sel)
                MS_N_SAB, MS_N_SAA, MS_N_SBB: tmp_reg   <= sprod;
                MS_SA_SB:                     num_reg   <= tmp_reg - sprod;
                MS_SA_SA:                     va_reg    <= tmp_reg - sprod;
                MS_SB_SB:                     vb_reg    <= tmp_reg - sprod;
                MS_MAG_MAG:                   magsq_reg <= p_reg;
                default:                      tmp_reg   <= tmp_reg;
            endcase
        end
    end

    // restoring division: num^2 * 2^60 / (va * vb)
    logic [PW:0]   rem_reg, div_sh;
    logic [QW-1:0] q_reg;
    logic          nbit_reg;

    assign div_sh = {rem_reg[PW-1:0], nbit_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg  <= {2'b00, magsq_reg[PW-1:1]};
            nbit_reg <= magsq_reg[0];
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            nbit_reg <= 1'b0;
            if (div_sh >= {1'b0, p_reg})
            begin
                rem_reg <= div_sh - {1'b0, p_reg};
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_sh;
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    // digit-by-digit integer square root
    logic [RW-1:0] x_reg, res_reg, bit_reg, root_t;

    assign root_t = res_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.root_load)
        begin
            x_reg   <= {1'b0, q_reg};
            res_reg <= '0;
            bit_reg <= RW'(1) << (RW - 2);
        end
        else if (cmd.root_step)
        begin
            bit_reg <= bit_reg >> 2;
            if (x_reg >= root_t)
            begin
                x_reg   <= x_reg - root_t;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
        end
    end

    // output register
    logic                     out_valid_reg;
    logic signed [COEF_W-1:0] coef_reg, coef_mag;
    logic [CNT_OUT_W-1:0]     pairs_reg;
    status_t                  status_reg, status_calc;

    assign coef_mag = COEF_W'(res_reg[ROOT_STEPS-1:0]);

    always_comb
    begin
        if (ovf_reg)
            status_calc = ST_OVF;
        else if (cnt_reg == '0)
            status_calc = ST_EMPTY;
        else if (va_reg == '0 || vb_reg == '0)
            status_calc = ST_FLAT;
        else
            status_calc = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= status_calc;
            pairs_reg  <= CNT_OUT_W'(cnt_reg);
            if (status_calc != ST_OK)
                coef_reg <= '0;
            else
                coef_reg <= num_reg[VW-1] ? -coef_mag : coef_mag;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign coefficient   = coef_reg;
    assign pairs_used    = pairs_reg;
    assign status        = status_reg;

endmodule

[rtl/pearson_correlation_skip_missing.sv]
// Pearson correlation of sample pairs, pairs with a missing sample skipped.
// Throughput: one pair per cycle while accumulating a set.
// After the last pair is taken the result is computed from the sums:
//   eight shift-add products, a 61-step divide and a 31-step root.
// No pair is taken during that computation.
// Reset (rst_n, async, low) clears the sums, the count and the output valid.
`timescale 1ns / 1ps
module pearson_correlation_skip_missing import pcs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    pcs_pair_if.sink     in_ch,
    pcs_result_if.source out_ch
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;
    logic     in_fire;

    assign in_fire     = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    pcs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_last  (in_ch.last_pair),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    pcs_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .a_sample    (in_ch.a_sample),
        .a_missing   (in_ch.a_missing),
        .b_sample    (in_ch.b_sample),
        .b_missing   (in_ch.b_missing),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .coefficient (out_ch.coefficient),
        .pairs_used  (out_ch.pairs_used),
        .status      (out_ch.status)
    );

endmodule

[rtl/pcs_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pcs_checker import pcs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     in_last,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [COEF_W-1:0] coefficient,
    input logic [CNT_OUT_W-1:0]     pairs_used,
    input logic [ST_W-1:0]          status
);

    localparam logic signed [COEF_W-1:0] ONE = COEF_W'(1) <<< 30;

    `PCS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(coefficient))
    `PCS_ASSERT_NXT(a_busy_after_last, clk, rst_n, in_valid && in_ready && in_last, !in_ready)
    `PCS_ASSERT_IMP(a_coef_range, clk, rst_n, out_valid, coefficient <= ONE && coefficient >= -ONE)
    `PCS_ASSERT_IMP(a_coef_zero_on_err, clk, rst_n, out_valid && status != ST_OK, coefficient == '0)
    `PCS_ASSERT_IMP(a_empty_count, clk, rst_n, out_valid && status == ST_EMPTY, pairs_used == '0)

endmodule

bind pearson_correlation_skip_missing pcs_checker u_pcs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_last     (in_ch.last_pair),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .coefficient (out_ch.coefficient),
    .pairs_used  (out_ch.pairs_used),
    .status      (out_ch.status)
);
